// ===== rtl/aad_pkg.sv =====
package aad_pkg;

  localparam int MAX_SRC_SIZE  = 4096;
  localparam int MAX_OUT_WIDTH = 1024;
  localparam int FRAC_BITS     = 16;

  localparam int REG_W   = 13;
  localparam int BOUND_W = 30;
  localparam int SUM_W   = 48;
  localparam int WSUM_W  = 41;
  localparam int WGT_W   = 17;

  localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] REG_FIT_WIDTH  = 3'd2;
  localparam logic [2:0] REG_FIT_HEIGHT = 3'd3;
  localparam logic [2:0] REG_OUT_WIDTH  = 3'd4;
  localparam logic [2:0] REG_OUT_HEIGHT = 3'd5;

  // One accumulator update for a destination pixel.
  typedef struct packed {
    logic              en;
    logic              row_odd;
    logic [11:0]       col;
    logic [WGT_W-1:0]  wgt;
  } acc_op_t;

  typedef struct packed {
    logic [SUM_W-1:0]  red;
    logic [SUM_W-1:0]  green;
    logic [SUM_W-1:0]  blue;
    logic [WSUM_W-1:0] wsum;
  } acc_word_t;

endpackage

// ===== rtl/aad_div.sv =====
// Bit-serial restoring divider: q = (num + den/2) / den, low 8 bits kept.
module aad_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [aad_pkg::SUM_W-1:0]  num,
  input  logic [aad_pkg::WSUM_W-1:0] den,
  output logic                      busy,
  output logic                      done,
  output logic [7:0]                quo
);
  localparam int NW = aad_pkg::SUM_W + 1;

  logic [NW-1:0]              dividend;
  logic [aad_pkg::WSUM_W:0]   divisor;
  logic [aad_pkg::WSUM_W+1:0] rem;
  logic [6:0]                 cnt;
  logic [aad_pkg::WSUM_W+1:0] shifted;
  logic                       fits;

  assign shifted = {rem[aad_pkg::WSUM_W:0], dividend[NW-1]};
  assign fits    = shifted >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        dividend <= {1'b0, num} + NW'(den >> 1);
        divisor  <= {1'b0, den};
        rem      <= '0;
        cnt      <= 7'(NW);
        quo      <= '0;
      end else if (busy) begin
        rem      <= fits ? shifted - {1'b0, divisor} : shifted;
        dividend <= {dividend[NW-2:0], fits};
        quo      <= {quo[6:0], fits};
        cnt      <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/area_average_downscale.sv =====
// Area-averaging RGB downscaler.
// Source pixels enter on s_axis (tdata = red, green, blue from bit 0) in
// raster order; destination pixels leave on m_axis (tdata = red, green,
// blue) with tuser high on the last pixel of the image.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user
// must write it only while idle, as the block does not enforce this.
// Every write restarts the image and starts a clearing pass over all
// 2*MAX_OUT_WIDTH accumulator words, during which no pixel is accepted.
// Reset does the same. Each accepted pixel steps through four accumulator
// updates on one memory port: an update of a kept destination pixel steps
// through weight, read, write and advance states, a skipped one through
// weight and advance only, and the next pixel is accepted only after all
// four updates are done. A finished destination pixel is read out and
// divided by a bit-serial divider, one channel after another; its result
// is then loaded into the output register, and no pixel is accepted until
// then. The result sits in the output register and the next pixel is
// accepted while it waits, but a new division waits for that register
// to drain. Invalid settings: pixels are accepted and dropped.
module area_average_downscale (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // in_red, in_green, in_blue
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // out_red, out_green, out_blue
  output logic        m_axis_tuser,   // image_done
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  localparam int MAX_OUT_WIDTH = aad_pkg::MAX_OUT_WIDTH;
  localparam int SLOTS = 2 * MAX_OUT_WIDTH;
  localparam int AW    = $clog2(SLOTS);
  localparam int BW    = aad_pkg::BOUND_W;
  localparam logic [BW-1:0] ONE = BW'(1) << aad_pkg::FRAC_BITS;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_STEP  = 9'b000000010,
    S_IDLE  = 9'b000000100,
    S_RD    = 9'b000001000,
    S_WR    = 9'b000010000,
    S_FRD   = 9'b000100000,
    S_FWAIT = 9'b001000000,
    S_DIV   = 9'b010000000,
    S_ADV   = 9'b100000000
  } state_t;

  state_t state;

  logic [12:0] src_width, src_height, fit_width, fit_height, out_height;
  logic [10:0] out_width;

  // step sizes via serial division
  logic [BW-1:0] step_x, step_y;
  logic [28:0]   sd_num;
  logic [12:0]   sd_den;
  logic [13:0]   sd_rem;
  logic [28:0]   sd_q;
  logic [5:0]    sd_cnt;
  logic          sd_y;
  logic [13:0]   sd_sh;

  aad_pkg::acc_word_t mem [SLOTS];
  aad_pkg::acc_word_t rd_word;
  logic [AW-1:0]      clr_addr;

  logic [11:0]   src_col, src_row;
  logic [BW-1:0] cx0, cx1, ry0, ry1;
  logic [11:0]   xi, yi;

  aad_pkg::acc_op_t ops [4];
  logic [1:0]  op_idx;
  logic [7:0]  pr, pg, pb;
  logic [aad_pkg::FRAC_BITS:0] wx0, wx1, wy0, wy1;
  logic        col_next, row_next, col_ends, row_ends;
  logic [BW-1:0] clo, chi, rlo, rhi;

  logic        fin_pend, fin_last;
  logic [AW-1:0] fin_addr;
  aad_pkg::acc_word_t fin_word;
  logic [1:0]  ch;
  logic [7:0]  res_r, res_g;

  logic        dv_start, dv_busy, dv_done;
  logic [aad_pkg::SUM_W-1:0] dv_num;
  logic [7:0]  dv_quo;

  logic valid_cfg;

  assign valid_cfg = src_width >= 13'd1 && src_width <= 13'(aad_pkg::MAX_SRC_SIZE)
    && src_height >= 13'd1 && src_height <= 13'(aad_pkg::MAX_SRC_SIZE)
    && fit_width >= 13'd1 && fit_width <= src_width
    && fit_height >= 13'd1 && fit_height <= src_height
    && out_width >= 11'd1 && 32'(out_width) <= 32'(MAX_OUT_WIDTH)
    && 13'(out_width) <= fit_width
    && out_height >= 13'd1 && out_height <= fit_height;

  assign clo = BW'(src_col) << aad_pkg::FRAC_BITS;
  assign chi = clo + ONE;
  assign rlo = BW'(src_row) << aad_pkg::FRAC_BITS;
  assign rhi = rlo + ONE;
  assign col_next = cx1 < chi;
  assign row_next = ry1 < rhi;
  assign col_ends = cx1 <= chi;
  assign row_ends = ry1 <= rhi;
  assign wx0 = 17'((col_next ? cx1 : chi) - (cx0 > clo ? cx0 : clo));
  assign wx1 = col_next ? 17'(chi - cx1) : '0;
  assign wy0 = 17'((row_next ? ry1 : rhi) - (ry0 > rlo ? ry0 : rlo));
  assign wy1 = row_next ? 17'(rhi - ry1) : '0;

  assign s_axis_tready = state == S_IDLE && !fin_pend;
  assign sd_sh = {sd_rem[12:0], sd_num[28]};

  // Register the weight operands of all four ops and multiply one op at a
  // time in S_STEP.
  logic [aad_pkg::FRAC_BITS:0] op_wy [4];
  logic [aad_pkg::FRAC_BITS:0] op_wx [4];
  logic [33:0] mul;
  assign mul = op_wy[op_idx] * op_wx[op_idx];

  always_ff @(posedge clk) begin
    if (state == S_CLEAR)
      mem[clr_addr] <= '0;
    else if (state == S_WR) begin
      mem[ops[op_idx].row_odd ? AW'(MAX_OUT_WIDTH) + AW'(ops[op_idx].col)
                              : AW'(ops[op_idx].col)] <= '{
        red:   rd_word.red + aad_pkg::SUM_W'(pr) * aad_pkg::SUM_W'(ops[op_idx].wgt),
        green: rd_word.green + aad_pkg::SUM_W'(pg) * aad_pkg::SUM_W'(ops[op_idx].wgt),
        blue:  rd_word.blue + aad_pkg::SUM_W'(pb) * aad_pkg::SUM_W'(ops[op_idx].wgt),
        wsum:  rd_word.wsum + aad_pkg::WSUM_W'(ops[op_idx].wgt)};
    end else if (state == S_FWAIT)
      mem[fin_addr] <= '0;
    if (state == S_RD)
      rd_word <= mem[ops[op_idx].row_odd ? AW'(MAX_OUT_WIDTH) + AW'(ops[op_idx].col)
                                         : AW'(ops[op_idx].col)];
    if (state == S_FRD)
      fin_word <= mem[fin_addr];
  end

  always_comb begin
    case (ch)
      2'd0:    dv_num = fin_word.red;
      2'd1:    dv_num = fin_word.green;
      default: dv_num = fin_word.blue;
    endcase
  end

  aad_div u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(dv_num), .den(fin_word.wsum),
    .busy(dv_busy), .done(dv_done), .quo(dv_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width <= 13'd1; src_height <= 13'd1; fit_width <= 13'd1;
      fit_height <= 13'd1; out_width <= 11'd1; out_height <= 13'd1;
      state <= S_CLEAR; clr_addr <= '0; sd_cnt <= 6'd30; sd_y <= 1'b0;
      sd_den <= 13'd1; sd_rem <= '0;
      m_axis_tvalid <= 1'b0; fin_pend <= 1'b0; dv_start <= 1'b0;
      src_col <= '0; src_row <= '0; xi <= '0; yi <= '0;
      sd_num <= 29'd1 << 16;
      cx0 <= '0; ry0 <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          aad_pkg::REG_SRC_WIDTH:  src_width  <= cfg_data;
          aad_pkg::REG_SRC_HEIGHT: src_height <= cfg_data;
          aad_pkg::REG_FIT_WIDTH:  fit_width  <= cfg_data;
          aad_pkg::REG_FIT_HEIGHT: fit_height <= cfg_data;
          aad_pkg::REG_OUT_WIDTH:  out_width  <= cfg_data[10:0];
          aad_pkg::REG_OUT_HEIGHT: out_height <= cfg_data;
          default: ;
        endcase
        state <= S_CLEAR; clr_addr <= '0; sd_cnt <= 6'd0; sd_y <= 1'b0;
        fin_pend <= 1'b0; dv_start <= 1'b0;
        src_col <= '0; src_row <= '0; xi <= '0; yi <= '0;
        cx0 <= '0; ry0 <= '0;
      end else begin
        case (state)
          S_CLEAR: begin
            // step division runs alongside the sweep
            if (sd_cnt == 6'd0) begin
              sd_num <= 29'(sd_y ? src_height : src_width) << 16;
              sd_den <= sd_y ? fit_height : fit_width;
              sd_rem <= '0; sd_q <= '0; sd_cnt <= 6'd30;
            end else if (sd_cnt != 6'd63) begin
              sd_rem <= (sd_den != 13'd0 && sd_sh >= {1'b0, sd_den})
                        ? sd_sh - {1'b0, sd_den} : sd_sh;
              sd_q   <= {sd_q[27:0], sd_den != 13'd0 && sd_sh >= {1'b0, sd_den}};
              sd_num <= {sd_num[27:0], 1'b0};
              if (sd_cnt == 6'd2) begin
                sd_cnt <= 6'd1;
              end else if (sd_cnt == 6'd1) begin
                if (!sd_y) begin
                  step_x <= sd_den == 13'd0 ? ONE : BW'(sd_q);
                  cx1 <= sd_den == 13'd0 ? ONE : BW'(sd_q);
                  sd_y <= 1'b1; sd_cnt <= 6'd0;
                end else begin
                  step_y <= sd_den == 13'd0 ? ONE : BW'(sd_q);
                  ry1 <= sd_den == 13'd0 ? ONE : BW'(sd_q);
                  sd_cnt <= 6'd63;
                end
              end else sd_cnt <= sd_cnt - 6'd1;
            end
            if (clr_addr != AW'(SLOTS - 1)) clr_addr <= clr_addr + AW'(1);
            else if (sd_cnt == 6'd63) begin
              clr_addr <= '0;
              state <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (s_axis_tvalid && s_axis_tready && valid_cfg) begin
              pr <= s_axis_tdata[7:0]; pg <= s_axis_tdata[15:8];
              pb <= s_axis_tdata[23:16];
              ops[0] <= '{en: 13'(yi) < out_height && xi < 12'(out_width),
                          row_odd: yi[0], col: xi, wgt: '0};
              ops[1] <= '{en: 13'(yi) < out_height && col_next
                              && xi + 12'd1 < 12'(out_width),
                          row_odd: yi[0], col: xi + 12'd1, wgt: '0};
              ops[2] <= '{en: row_next && 13'(yi) + 13'd1 < out_height
                              && xi < 12'(out_width),
                          row_odd: ~yi[0], col: xi, wgt: '0};
              ops[3] <= '{en: row_next && 13'(yi) + 13'd1 < out_height && col_next
                              && xi + 12'd1 < 12'(out_width),
                          row_odd: ~yi[0], col: xi + 12'd1, wgt: '0};
              op_wy[0] <= wy0; op_wx[0] <= wx0;
              op_wy[1] <= wy0; op_wx[1] <= wx1;
              op_wy[2] <= wy1; op_wx[2] <= wx0;
              op_wy[3] <= wy1; op_wx[3] <= wx1;
              fin_pend <= col_ends && row_ends && xi < 12'(out_width)
                          && 13'(yi) < out_height;
              fin_addr <= yi[0] ? AW'(MAX_OUT_WIDTH) + AW'(xi) : AW'(xi);
              fin_last <= xi + 12'd1 == 12'(out_width)
                          && 13'(yi) + 13'd1 == out_height;
              op_idx <= '0;
              state <= S_STEP;
            end
          end
          S_STEP: begin
            ops[op_idx].wgt <= 17'(mul >> aad_pkg::FRAC_BITS);
            state <= ops[op_idx].en ? S_RD : S_ADV;
          end
          S_RD: state <= S_WR;
          S_WR: state <= S_ADV;
          S_ADV: begin
            if (op_idx != 2'd3) begin
              op_idx <= op_idx + 2'd1;
              state <= S_STEP;
            end else begin
              if (32'(src_col) + 1 >= 32'(src_width)) begin
                src_col <= '0; xi <= '0; cx0 <= '0; cx1 <= step_x;
                if (32'(src_row) + 1 >= 32'(src_height)) begin
                  src_row <= '0; yi <= '0; ry0 <= '0; ry1 <= step_y;
                end else begin
                  src_row <= src_row + 12'd1;
                  if (row_ends && 13'(yi) < out_height) begin
                    yi <= yi + 12'd1; ry0 <= ry1; ry1 <= ry1 + step_y;
                  end
                end
              end else begin
                src_col <= src_col + 12'd1;
                if (col_ends && xi < 12'(out_width)) begin
                  xi <= xi + 12'd1; cx0 <= cx1; cx1 <= cx1 + step_x;
                end
              end
              state <= fin_pend ? S_FRD : S_IDLE;
            end
          end
          S_FRD: state <= S_FWAIT;
          S_FWAIT: begin
            if ((!m_axis_tvalid || m_axis_tready) && !dv_busy) begin
              ch <= 2'd0; dv_start <= 1'b1; state <= S_DIV;
            end
          end
          S_DIV: begin
            dv_start <= dv_done && ch != 2'd2;
            if (dv_done) begin
              case (ch)
                2'd0: begin res_r <= dv_quo; ch <= 2'd1; end
                2'd1: begin res_g <= dv_quo; ch <= 2'd2; end
                default: begin
                  m_axis_tdata  <= {dv_quo, res_g, res_r};
                  m_axis_tuser  <= fin_last;
                  m_axis_tvalid <= 1'b1;
                  fin_pend <= 1'b0;
                  state <= S_IDLE;
                end
              endcase
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end
endmodule

// ===== tb/area_average_downscale_tb.sv =====
module area_average_downscale_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS       = 2 * aad_pkg::MAX_OUT_WIDTH;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE      = 400;
  localparam int TARGET      = 1800;

  typedef bit  bool_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       done;
  } dest_pixel_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [12:0] cfg_data = '0;

  area_average_downscale uut (.*);

  // scaler settings and accumulator state as the block should hold them
  int unsigned src_w, src_h, fit_w, fit_h, kept_w, kept_h;
  longint unsigned red_acc [SLOTS];
  longint unsigned green_acc [SLOTS];
  longint unsigned blue_acc [SLOTS];
  longint unsigned weight_acc [SLOTS];
  int unsigned src_col, src_row, dst_col, dst_row;
  longint unsigned col_lo, col_hi, row_lo, row_hi;

  pixel_t      pixel_queue [$];
  dest_pixel_t dest_queue [$];
  int          pixels_queued = 0;
  int          dest_seen = 0;
  int          mismatches = 0;
  int          cycles = 0;
  bool_t       steady_source;
  bool_t       steady_sink;

  function automatic longint unsigned span(int unsigned s, int unsigned f);
    return f == 0 ? 64'd65536 : (longint'(s) << aad_pkg::FRAC_BITS) / f;
  endfunction

  function automatic bit settings_ok();
    if (src_w < 1 || src_w > aad_pkg::MAX_SRC_SIZE || src_h < 1
        || src_h > aad_pkg::MAX_SRC_SIZE) return 0;
    if (fit_w < 1 || fit_w > src_w || fit_h < 1 || fit_h > src_h) return 0;
    if (kept_w < 1 || kept_w > aad_pkg::MAX_OUT_WIDTH || kept_w > fit_w) return 0;
    if (kept_h < 1 || kept_h > fit_h) return 0;
    return 1;
  endfunction

  task automatic restart_image();
    for (int i = 0; i < SLOTS; i++) begin
      red_acc[i] = 0;
      green_acc[i] = 0;
      blue_acc[i] = 0;
      weight_acc[i] = 0;
    end
    src_col = 0;
    src_row = 0;
    dst_col = 0;
    dst_row = 0;
    col_lo = 0;
    col_hi = span(src_w, fit_w);
    row_lo = 0;
    row_hi = span(src_h, fit_h);
  endtask

  task automatic set_reg(logic [2:0] idx, logic [12:0] val);
    case (idx)
      aad_pkg::REG_SRC_WIDTH:  src_w = val;
      aad_pkg::REG_SRC_HEIGHT: src_h = val;
      aad_pkg::REG_FIT_WIDTH:  fit_w = val;
      aad_pkg::REG_FIT_HEIGHT: fit_h = val;
      aad_pkg::REG_OUT_WIDTH:  kept_w = val[10:0];
      aad_pkg::REG_OUT_HEIGHT: kept_h = val;
      default: ;
    endcase
    restart_image();
  endtask

  task automatic add_area(int unsigned row, int unsigned col, longint unsigned wy,
                          longint unsigned wx, pixel_t p);
    int unsigned     slot;
    longint unsigned w;
    slot = (row & 1) * aad_pkg::MAX_OUT_WIDTH + col;
    w = (wy * wx) >> aad_pkg::FRAC_BITS;
    red_acc[slot] += p.red * w;
    green_acc[slot] += p.green * w;
    blue_acc[slot] += p.blue * w;
    weight_acc[slot] += w;
  endtask

  function automatic logic [7:0] rounded(longint unsigned sum, longint unsigned w);
    return w == 0 ? 8'd0 : 8'((sum + w / 2) / w);
  endfunction

  // fold one source pixel into the destination windows it overlaps
  task automatic average_pixel(pixel_t p);
    longint unsigned sx, sy, clo, chi, rlo, rhi, wx0, wx1, wy0, wy1;
    bit              col_next, row_next, col_ends, row_ends;
    int unsigned     xi, yi, slot;
    dest_pixel_t     d;
    if (!settings_ok()) return;
    xi = dst_col;
    yi = dst_row;
    wx1 = 0;
    wy1 = 0;
    sx = span(src_w, fit_w);
    sy = span(src_h, fit_h);
    clo = longint'(src_col) << aad_pkg::FRAC_BITS;
    chi = clo + 65536;
    rlo = longint'(src_row) << aad_pkg::FRAC_BITS;
    rhi = rlo + 65536;
    wx0 = (col_hi < chi ? col_hi : chi) - (col_lo > clo ? col_lo : clo);
    col_next = col_hi < chi;
    if (col_next) wx1 = chi - col_hi;
    wy0 = (row_hi < rhi ? row_hi : rhi) - (row_lo > rlo ? row_lo : rlo);
    row_next = row_hi < rhi;
    if (row_next) wy1 = rhi - row_hi;
    if (yi < kept_h) begin
      if (xi < kept_w) add_area(yi, xi, wy0, wx0, p);
      if (col_next && xi + 1 < kept_w) add_area(yi, xi + 1, wy0, wx1, p);
    end
    if (row_next && yi + 1 < kept_h) begin
      if (xi < kept_w) add_area(yi + 1, xi, wy1, wx0, p);
      if (col_next && xi + 1 < kept_w) add_area(yi + 1, xi + 1, wy1, wx1, p);
    end
    col_ends = col_hi <= chi;
    row_ends = row_hi <= rhi;
    if (col_ends && row_ends && xi < kept_w && yi < kept_h) begin
      slot = (yi & 1) * aad_pkg::MAX_OUT_WIDTH + xi;
      d.red = rounded(red_acc[slot], weight_acc[slot]);
      d.green = rounded(green_acc[slot], weight_acc[slot]);
      d.blue = rounded(blue_acc[slot], weight_acc[slot]);
      d.done = (xi + 1 == kept_w) && (yi + 1 == kept_h);
      dest_queue.push_back(d);
      red_acc[slot] = 0;
      green_acc[slot] = 0;
      blue_acc[slot] = 0;
      weight_acc[slot] = 0;
    end
    if (col_ends && xi < kept_w) begin
      dst_col = xi + 1;
      col_lo = col_hi;
      col_hi = col_hi + sx;
    end
    src_col++;
    if (src_col >= src_w) begin
      src_col = 0;
      dst_col = 0;
      col_lo = 0;
      col_hi = sx;
      if (row_ends && yi < kept_h) begin
        dst_row = yi + 1;
        row_lo = row_hi;
        row_hi = row_hi + sy;
      end
      src_row++;
      if (src_row >= src_h) begin
        src_row = 0;
        dst_row = 0;
        row_lo = 0;
        row_hi = sy;
      end
    end
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // source side: one pixel per beat from the queue
  int src_gap = 0;
  always @(posedge clk) begin
    pixel_t p;
    bit     offer;
    if (rst) begin
      s_axis_tvalid <= 0;
    end else begin
      offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        average_pixel('{s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]});
        offer = 0;
      end
      if (!offer) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
        end else if (pixel_queue.size() > 0) begin
          p = pixel_queue.pop_front();
          s_axis_tdata <= {p.blue, p.green, p.red};
          offer = 1;
          src_gap <= steady_source ? 0 : gap_len();
        end
      end
      s_axis_tvalid <= offer;
    end
  end

  // hold off once for a long stretch so the block backs up
  int long_hold = 0;
  bit held_once = 0;
  always @(posedge clk) begin
    if (rst) begin
      long_hold <= 0;
    end else if (!held_once && dest_seen == 60) begin
      held_once <= 1;
      long_hold <= 3000;
    end else if (long_hold > 0) begin
      long_hold <= long_hold - 1;
    end
  end

  // destination side: compare each beat with the oldest expected pixel
  int sink_gap = 0;
  always @(posedge clk) begin
    dest_pixel_t e;
    if (rst) begin
      m_axis_tready <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        dest_seen <= dest_seen + 1;
        if (dest_queue.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("unexpected pixel %h done %b", m_axis_tdata, m_axis_tuser);
        end else begin
          e = dest_queue.pop_front();
          if (m_axis_tdata !== {e.blue, e.green, e.red} || m_axis_tuser !== e.done) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("pixel mismatch: expected %h done %b, got %h done %b",
                       {e.blue, e.green, e.red}, e.done, m_axis_tdata, m_axis_tuser);
          end
        end
      end
      if (long_hold > 0 || (!held_once && dest_seen == 60)) begin
        m_axis_tready <= 0;
      end else if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= 1;
        sink_gap <= steady_sink ? 0 : gap_len();
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [12:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    set_reg(idx, val);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic setup(int sw, int sh, int fw, int fh, int ow, int oh);
    write_reg(aad_pkg::REG_SRC_WIDTH, 13'(sw));
    write_reg(aad_pkg::REG_SRC_HEIGHT, 13'(sh));
    write_reg(aad_pkg::REG_FIT_WIDTH, 13'(fw));
    write_reg(aad_pkg::REG_FIT_HEIGHT, 13'(fh));
    write_reg(aad_pkg::REG_OUT_WIDTH, 13'(ow));
    write_reg(aad_pkg::REG_OUT_HEIGHT, 13'(oh));
  endtask

  task automatic send(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pixel_t p;
    p.red = r;
    p.green = g;
    p.blue = b;
    pixel_queue.push_back(p);
    pixels_queued++;
  endtask

  function automatic logic [7:0] color();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom);
  endfunction

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) send(color(), color(), color());
  endtask

  // wait for every pixel to go in and every result to come out
  task automatic drain();
    while (pixel_queue.size() != 0 || s_axis_tvalid || dest_queue.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int sw, sh, fw, fh, ow, oh;
    steady_source = 0;
    steady_sink = 0;
    set_reg(aad_pkg::REG_SRC_WIDTH, 1);
    set_reg(aad_pkg::REG_SRC_HEIGHT, 1);
    set_reg(aad_pkg::REG_FIT_WIDTH, 1);
    set_reg(aad_pkg::REG_FIT_HEIGHT, 1);
    set_reg(aad_pkg::REG_OUT_WIDTH, 1);
    set_reg(aad_pkg::REG_OUT_HEIGHT, 1);
    repeat (3) @(posedge clk);
    rst <= 0;

    // one-to-one image: every pixel comes back as the last of its image
    send(8'h00, 8'h00, 8'h00);
    send(8'hff, 8'hff, 8'hff);
    send(8'hff, 8'h00, 8'h00);
    send(8'h00, 8'hff, 8'h00);
    send(8'h00, 8'h00, 8'hff);
    send(8'h55, 8'haa, 8'h55);
    send(8'haa, 8'h55, 8'haa);
    drain();

    // enlarging settings: pixels go in, nothing comes out
    setup(2, 2, 3, 2, 1, 1);
    send_random(3);
    drain();
    // unknown register only restarts the image
    write_reg(3'd6, 13'h1fff);
    write_reg(3'd7, 13'h0);
    setup(3, 3, 2, 2, 2, 2);
    send_random(9);
    drain();

    // widest source and kept width, cut off after the kept columns
    steady_source = 1;
    steady_sink = 1;
    setup(4096, 1, 4096, 1, 1024, 1);
    send_random(1024);
    drain();
    // tallest source, crop down to two rows
    steady_source = 0;
    setup(1, 4096, 1, 4096, 1, 2);
    send_random(64);
    drain();
    // zero register and an out width wider than its field
    steady_sink = 0;
    setup(0, 2, 1, 1, 1, 1);
    send_random(2);
    drain();
    setup(4, 2, 4, 2, 13'h1400, 1);
    send_random(8);
    drain();

    while (pixels_queued < TARGET) begin
      steady_source = ($urandom_range(0, 3) == 0);
      steady_sink = ($urandom_range(0, 3) == 0);
      sw = $urandom_range(1, 12);
      sh = $urandom_range(1, 8);
      fw = $urandom_range(1, sw);
      fh = $urandom_range(1, sh);
      ow = $urandom_range(1, fw);
      oh = $urandom_range(1, fh);
      if ($urandom_range(0, 9) == 0) fw = sw + 1;
      setup(sw, sh, fw, fh, ow, oh);
      send_random(sw * sh * $urandom_range(1, 3));
      // now and then a cut-off image
      if ($urandom_range(0, 4) == 0) send_random($urandom_range(1, sw * sh));
      drain();
    end

    if (mismatches == 0 && dest_queue.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/aad_pkg.sv
rtl/aad_div.sv
rtl/area_average_downscale.sv
tb/area_average_downscale_tb.sv
